@@ hdl/smmsa_pkg.sv @@
// ----------------------------------------------------------------------------
// smmsa_pkg
// Shared types and constants for the small matrix multiply, scale and add
// block: operation codes, register indexes and the controller command word.
// ----------------------------------------------------------------------------
package smmsa_pkg;

    // store geometry: 8 by 8 grid, addressed as row*8 + column
    localparam int GRID   = 8;
    localparam int IDX_W  = 3;
    localparam int ADDR_W = 2 * IDX_W;
    localparam int VAL_W  = 16;
    localparam int DIM_W  = 4;

    // datapath widths
    localparam int PROD_W  = 2 * VAL_W;           // one element product
    localparam int ACC_W   = PROD_W + IDX_W;      // sum of up to eight products
    localparam int ALPHA_W = VAL_W + ACC_W;       // alpha * sum
    localparam int TOTAL_W = ALPHA_W + 1;         // alpha term plus aligned beta term
    localparam int FRAC_SH = 16;                  // 24 fraction bits down to 8
    localparam int SHIFT_W = TOTAL_W - FRAC_SH;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = VAL_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROWS_M      = 3'd0,
        REG_COLS_N      = 3'd1,
        REG_DEPTH_K     = 3'd2,
        REG_ALPHA_SCALE = 3'd3,
        REG_BETA_SCALE  = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_LOAD_C  = 2'd2,
        OP_COMPUTE = 2'd3
    } op_t;

    // command word from controller to datapath
    typedef struct packed {
        logic             load_a;    // write element into A store
        logic             load_b;    // write element into B store
        logic             load_c;    // write element into C store
        logic             rd_en;     // read A[m][k], B[k][n], C[m][n]
        logic             acc_clr;   // start a fresh dot product
        logic             scale_en;  // form alpha*sum and beta*C
        logic             emit;      // add, shift, saturate, write back, show
        logic             last;      // final element of the matrix
        logic [IDX_W-1:0] m;
        logic [IDX_W-1:0] n;
        logic [IDX_W-1:0] k;
    } dp_cmd_t;

endpackage

@@ hdl/smmsa_ctrl.sv @@
// ----------------------------------------------------------------------------
// smmsa_ctrl
// Controller: decodes accepted words, walks the m, n, k loops of a compute
// word and issues one command word per cycle to the datapath.
// ----------------------------------------------------------------------------
module smmsa_ctrl
    import smmsa_pkg::*;
#(
    parameter int MAX_M = 8,
    parameter int MAX_N = 8,
    parameter int MAX_K = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [1:0]       operation,
    input  logic [DIM_W-1:0] rows_m,
    input  logic [DIM_W-1:0] cols_n,
    input  logic [DIM_W-1:0] depth_k,
    output logic             busy,
    output dp_cmd_t          cmd
);

    localparam int LIM_M = (MAX_M > GRID) ? GRID : MAX_M;
    localparam int LIM_N = (MAX_N > GRID) ? GRID : MAX_N;
    localparam int LIM_K = (MAX_K > GRID) ? GRID : MAX_K;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_READ   = 6'b000010,
        S_DRAIN1 = 6'b000100,
        S_DRAIN2 = 6'b001000,
        S_SCALE  = 6'b010000,
        S_EMIT   = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] m_reg, m_next;
    logic [IDX_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] m_last_reg, m_last_next;
    logic [IDX_W-1:0] n_last_reg, n_last_next;
    logic [IDX_W-1:0] k_last_reg, k_last_next;
    logic             op_compute;
    logic             at_end;

    // clamp a size register to 1..limit and return the clamped size minus 1 as an index
    function automatic logic [IDX_W-1:0] last_index(input logic [DIM_W-1:0] v,
                                                    input int limit);
        logic [DIM_W-1:0] lim;
        lim = DIM_W'(limit);
        if (v == '0)
            return '0;
        else if (v > lim)
            return IDX_W'(lim - DIM_W'(1));
        else
            return IDX_W'(v - DIM_W'(1));
    endfunction

    assign op_compute = (op_t'(operation) == OP_COMPUTE);
    assign at_end     = (m_reg == m_last_reg) && (n_reg == n_last_reg);
    assign busy       = (state_reg != S_IDLE);

    // next state and loop counters
    always_comb
    begin
        state_next  = state_reg;
        m_next      = m_reg;
        n_next      = n_reg;
        k_next      = k_reg;
        m_last_next = m_last_reg;
        n_last_next = n_last_reg;
        k_last_next = k_last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && op_compute)
                begin
                    m_last_next = last_index(rows_m, LIM_M);
                    n_last_next = last_index(cols_n, LIM_N);
                    k_last_next = last_index(depth_k, LIM_K);
                    m_next      = '0;
                    n_next      = '0;
                    k_next      = '0;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                if (k_reg == k_last_reg)
                begin
                    k_next     = '0;
                    state_next = S_DRAIN1;
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            S_DRAIN1: state_next = S_DRAIN2;
            S_DRAIN2: state_next = S_SCALE;
            S_SCALE:  state_next = S_EMIT;
            S_EMIT:
            begin
                if (at_end)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_READ;
                    if (n_reg == n_last_reg)
                    begin
                        n_next = '0;
                        m_next = m_reg + IDX_W'(1);
                    end
                    else
                    begin
                        n_next = n_reg + IDX_W'(1);
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            m_reg      <= '0;
            n_reg      <= '0;
            k_reg      <= '0;
            m_last_reg <= '0;
            n_last_reg <= '0;
            k_last_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            m_reg      <= m_next;
            n_reg      <= n_next;
            k_reg      <= k_next;
            m_last_reg <= m_last_next;
            n_last_reg <= n_last_next;
            k_last_reg <= k_last_next;
        end
    end

    // command word
    always_comb
    begin
        cmd          = '0;
        cmd.m        = m_reg;
        cmd.n        = n_reg;
        cmd.k        = k_reg;
        cmd.load_a   = accept && (op_t'(operation) == OP_LOAD_A);
        cmd.load_b   = accept && (op_t'(operation) == OP_LOAD_B);
        cmd.load_c   = accept && (op_t'(operation) == OP_LOAD_C);
        cmd.rd_en    = (state_reg == S_READ);
        cmd.acc_clr  = (state_reg == S_READ) && (k_reg == '0);
        cmd.scale_en = (state_reg == S_SCALE);
        cmd.emit     = (state_reg == S_EMIT);
        cmd.last     = (state_reg == S_EMIT) && at_end;
    end

endmodule

@@ hdl/smmsa_datapath.sv @@
// ----------------------------------------------------------------------------
// smmsa_datapath
// Element stores, multiply-accumulate pipeline, alpha/beta scaling,
// shift and saturation, C write-back and the result register.
// ----------------------------------------------------------------------------
module smmsa_datapath
    import smmsa_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  dp_cmd_t                 cmd,
    input  logic [IDX_W-1:0]        row_index,
    input  logic [IDX_W-1:0]        col_index,
    input  logic signed [VAL_W-1:0] element_value,
    input  logic signed [VAL_W-1:0] alpha_scale,
    input  logic signed [VAL_W-1:0] beta_scale,
    output logic                    result_valid,
    output logic [IDX_W-1:0]        out_row,
    output logic [IDX_W-1:0]        out_col,
    output logic signed [VAL_W-1:0] out_value,
    output logic                    last_result
);

    logic signed [VAL_W-1:0]   a_mem [GRID*GRID];
    logic signed [VAL_W-1:0]   b_mem [GRID*GRID];
    logic signed [VAL_W-1:0]   c_mem [GRID*GRID];

    logic signed [VAL_W-1:0]   a_rd_reg, b_rd_reg, c_rd_reg;
    logic                      rd_v_reg, mul_v_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ALPHA_W-1:0] alpha_prod_reg;
    logic signed [PROD_W-1:0]  beta_prod_reg;

    logic [ADDR_W-1:0]         load_addr;
    logic [ADDR_W-1:0]         c_wr_addr;
    logic signed [VAL_W-1:0]   c_wr_data;
    logic signed [TOTAL_W-1:0] total;
    logic signed [SHIFT_W-1:0] shifted;
    logic signed [VAL_W-1:0]   sat_value;

    assign load_addr = {row_index, col_index};

    // A and B stores: load writes, registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.load_a)
            a_mem[load_addr] <= element_value;
        if (cmd.load_b)
            b_mem[load_addr] <= element_value;
        if (cmd.rd_en)
        begin
            a_rd_reg <= a_mem[{cmd.m, cmd.k}];
            b_rd_reg <= b_mem[{cmd.k, cmd.n}];
        end
    end

    // C store: load or write-back of the result
    assign c_wr_addr = cmd.load_c ? load_addr : {cmd.m, cmd.n};
    assign c_wr_data = cmd.load_c ? element_value : sat_value;

    always_ff @(posedge clk)
    begin
        if (cmd.load_c || cmd.emit)
            c_mem[c_wr_addr] <= c_wr_data;
        if (cmd.rd_en)
            c_rd_reg <= c_mem[{cmd.m, cmd.n}];
    end

    // pipeline valids for multiply and accumulate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg  <= 1'b0;
            mul_v_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg  <= cmd.rd_en;
            mul_v_reg <= rd_v_reg;
        end
    end

    // multiply, accumulate, scale
    always_ff @(posedge clk)
    begin
        if (rd_v_reg)
            prod_reg <= a_rd_reg * b_rd_reg;
        if (cmd.acc_clr)
            acc_reg <= '0;
        else if (mul_v_reg)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        if (cmd.scale_en)
        begin
            alpha_prod_reg <= ALPHA_W'(alpha_scale) * acc_reg;
            beta_prod_reg  <= beta_scale * c_rd_reg;
        end
    end

    // align beta term, add, floor shift and saturate
    always_comb
    begin
        total   = TOTAL_W'(alpha_prod_reg) + (TOTAL_W'(beta_prod_reg) <<< 8);
        shifted = total[TOTAL_W-1:FRAC_SH];
        if (shifted > SHIFT_W'(32767))
            sat_value = 16'sh7FFF;
        else if (shifted < -SHIFT_W'(32768))
            sat_value = 16'sh8000;
        else
            sat_value = shifted[VAL_W-1:0];
    end

    // result register: one strobe per word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid <= 1'b0;
            last_result  <= 1'b0;
        end
        else
        begin
            result_valid <= cmd.emit;
            last_result  <= cmd.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_row   <= cmd.m;
            out_col   <= cmd.n;
            out_value <= sat_value;
        end
    end

endmodule

@@ hdl/small_matrix_multiply_scale_add.sv @@
// ----------------------------------------------------------------------------
// small_matrix_multiply_scale_add
// C = alpha*A*B + beta*C on matrices of up to 8 by 8 signed Q8.8 elements.
// ----------------------------------------------------------------------------
// Load words (A, B or C element) leave busy low, so loads can be issued back
// to back. A compute word raises busy and walks the result elements in
// row-major order; each element takes K reads through the single read port
// of each store into one shared multiply-accumulate unit, the pipeline drain
// states S_DRAIN1 and S_DRAIN2, the scaling state and the output state. Each
// result is on the output ports for exactly one cycle behind result_valid and
// must be taken then: there is no back-pressure. Results are also written
// back into C.
// ----------------------------------------------------------------------------
module small_matrix_multiply_scale_add
    import smmsa_pkg::*;
#(
    parameter int MAX_M = 8,
    parameter int MAX_N = 8,
    parameter int MAX_K = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    // command channel
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              operation,
    input  logic [IDX_W-1:0]        row_index,
    input  logic [IDX_W-1:0]        col_index,
    input  logic signed [VAL_W-1:0] element_value,
    // configuration write port
    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    // result channel
    output logic                    result_valid,
    output logic [IDX_W-1:0]        out_row,
    output logic [IDX_W-1:0]        out_col,
    output logic signed [VAL_W-1:0] out_value,
    output logic                    last_result
);

    logic [DIM_W-1:0]        rows_m_reg;
    logic [DIM_W-1:0]        cols_n_reg;
    logic [DIM_W-1:0]        depth_k_reg;
    logic signed [VAL_W-1:0] alpha_scale_reg;
    logic signed [VAL_W-1:0] beta_scale_reg;
    logic                    accept;
    dp_cmd_t                 cmd;

    assign accept = start && !busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_m_reg      <= DIM_W'(8);
            cols_n_reg      <= DIM_W'(8);
            depth_k_reg     <= DIM_W'(8);
            alpha_scale_reg <= 16'sd256;
            beta_scale_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ROWS_M:      rows_m_reg      <= cfg_data[DIM_W-1:0];
                REG_COLS_N:      cols_n_reg      <= cfg_data[DIM_W-1:0];
                REG_DEPTH_K:     depth_k_reg     <= cfg_data[DIM_W-1:0];
                REG_ALPHA_SCALE: alpha_scale_reg <= cfg_data;
                REG_BETA_SCALE:  beta_scale_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    smmsa_ctrl #(
        .MAX_M (MAX_M),
        .MAX_N (MAX_N),
        .MAX_K (MAX_K)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .operation (operation),
        .rows_m    (rows_m_reg),
        .cols_n    (cols_n_reg),
        .depth_k   (depth_k_reg),
        .busy      (busy),
        .cmd       (cmd)
    );

    smmsa_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .row_index     (row_index),
        .col_index     (col_index),
        .element_value (element_value),
        .alpha_scale   (alpha_scale_reg),
        .beta_scale    (beta_scale_reg),
        .result_valid  (result_valid),
        .out_row       (out_row),
        .out_col       (out_col),
        .out_value     (out_value),
        .last_result   (last_result)
    );

`ifndef ASSERT_OFF
    // a result word only follows a busy cycle
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result word without a compute in progress");

    // the last flag only rides on a result word
    a_last_with_valid: assert property (@(posedge clk) disable iff (!rst_n)
        last_result |-> result_valid)
        else $error("last flag without result word");

    // busy has dropped by the time the final word is shown
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        last_result |-> !busy)
        else $error("still busy on the final result word");
`endif

endmodule

@@ dv/small_matrix_multiply_scale_add_test.sv @@
// ----------------------------------------------------------------------------
// small_matrix_multiply_scale_add_test
// Self-checking bench for the alpha/beta matrix multiply block. Load and
// compute words are driven on the command channel, and a local model of the
// three element stores predicts every result word, which is compared field
// by field as it leaves the block. Covers saturation, floor rounding, size
// clamping, spare register indexes and random load/compute sequences.
// ----------------------------------------------------------------------------
module small_matrix_multiply_scale_add_test;
    import smmsa_pkg::*;

    localparam int ITEM_TARGET    = 150;
    localparam int QUIET_TAIL     = 30;
    localparam int CFG_SETTLE     = 4;
    localparam int END_SETTLE     = 32;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam longint VAL_MAX    = 32767;
    localparam longint VAL_MIN    = -32768;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [VAL_W-1:0] value;
        logic             last;
    } result_word_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [1:0]              operation;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [VAL_W-1:0] element_value;
    logic                    cfg_write;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    result_valid;
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [VAL_W-1:0] out_value;
    logic                    last_result;

    // local copy of the stores and registers
    logic [VAL_W-1:0] a_mem [GRID*GRID];
    logic [VAL_W-1:0] b_mem [GRID*GRID];
    logic [VAL_W-1:0] c_mem [GRID*GRID];
    bit               a_set [GRID*GRID];
    bit               b_set [GRID*GRID];
    bit               c_set [GRID*GRID];
    logic [DIM_W-1:0] dim_m   = 4'd8;
    logic [DIM_W-1:0] dim_n   = 4'd8;
    logic [DIM_W-1:0] dim_k   = 4'd8;
    logic [VAL_W-1:0] alpha_q = 16'h0100;
    logic [VAL_W-1:0] beta_q  = 16'h0000;

    result_word_t pending_elements[$];
    int           words_sent   = 0;
    int           mismatches   = 0;
    int           quiet_cycles = 0;
    bit           gaps_on      = 1'b1;

    small_matrix_multiply_scale_add u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .row_index     (row_index),
        .col_index     (col_index),
        .element_value (element_value),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result_valid  (result_valid),
        .out_row       (out_row),
        .out_col       (out_col),
        .out_value     (out_value),
        .last_result   (last_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // size register as the block uses it: 0 reads as 1, anything above 8 as 8
    function automatic int eff_dim(logic [DIM_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > GRID)
            return GRID;
        return int'(v);
    endfunction

    // C = alpha*A*B + beta*C over the live sizes, written back into C
    function automatic void predict_matrix_results();
        int           m_lim;
        int           n_lim;
        int           k_lim;
        int           m;
        int           n;
        int           k;
        longint       dot;
        longint       total;
        result_word_t w;
        m_lim = eff_dim(dim_m);
        n_lim = eff_dim(dim_n);
        k_lim = eff_dim(dim_k);
        for (m = 0; m < m_lim; m++)
        begin
            for (n = 0; n < n_lim; n++)
            begin
                dot = 0;
                for (k = 0; k < k_lim; k++)
                    dot += longint'($signed(a_mem[m*GRID+k])) *
                           longint'($signed(b_mem[k*GRID+n]));
                total = longint'($signed(alpha_q)) * dot +
                        longint'($signed(beta_q)) * longint'($signed(c_mem[m*GRID+n])) * 256;
                // 24 fraction bits down to 8, floor rounding
                total = total >>> FRAC_SH;
                if (total > VAL_MAX)
                    total = VAL_MAX;
                else if (total < VAL_MIN)
                    total = VAL_MIN;
                w.row   = IDX_W'(m);
                w.col   = IDX_W'(n);
                w.value = VAL_W'(total);
                w.last  = (m == m_lim - 1) && (n == n_lim - 1);
                c_mem[m*GRID+n] = w.value;
                c_set[m*GRID+n] = 1'b1;
                pending_elements.push_back(w);
            end
        end
    endfunction

    function automatic logic [VAL_W-1:0] rand_element();
        case ($urandom_range(0, 5)) inside
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            [2:3]:   return VAL_W'($urandom_range(0, 1023) - 512);
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] rand_scale();
        case ($urandom_range(0, 5))
            0:       return 16'h0100;
            1:       return 16'h7FFF;
            2:       return 16'h8000;
            3:       return 16'h0000;
            4:       return VAL_W'($urandom_range(0, 2047) - 1024);
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // lower start for a while
    task automatic hold_off(int cycles);
        @(negedge clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    // one command word; start is left high for a following word
    task automatic send_word(op_t op, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                             logic [VAL_W-1:0] value);
        @(negedge clk);
        start         <= 1'b1;
        operation     <= op;
        row_index     <= row;
        col_index     <= col;
        element_value <= value;
        while (busy !== 1'b0)
            @(negedge clk);
        @(posedge clk);
        case (op)
            OP_LOAD_A:
            begin
                a_mem[{row, col}] = value;
                a_set[{row, col}] = 1'b1;
            end
            OP_LOAD_B:
            begin
                b_mem[{row, col}] = value;
                b_set[{row, col}] = 1'b1;
            end
            OP_LOAD_C:
            begin
                c_mem[{row, col}] = value;
                c_set[{row, col}] = 1'b1;
            end
            default:   predict_matrix_results();
        endcase
        words_sent++;
        if (gaps_on && $urandom_range(0, 3) == 0)
            hold_off($urandom_range(1, 9));
    endtask

    task automatic issue_compute();
        send_word(OP_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), VAL_W'($urandom));
    endtask

    // hold the sender until every expected word is out and the block is idle
    task automatic wait_idle(int settle);
        @(negedge clk);
        start <= 1'b0;
        while (pending_elements.size() != 0 || busy !== 1'b0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    // register write; only called while the block is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        start     <= 1'b0;
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_ROWS_M:      dim_m   = data[DIM_W-1:0];
            REG_COLS_N:      dim_n   = data[DIM_W-1:0];
            REG_DEPTH_K:     dim_k   = data[DIM_W-1:0];
            REG_ALPHA_SCALE: alpha_q = data;
            REG_BETA_SCALE:  beta_q  = data;
            default:         ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // size writes carry random junk above the 4 live bits
    task automatic set_shape(logic [DIM_W-1:0] rows, logic [DIM_W-1:0] cols,
                             logic [DIM_W-1:0] depth);
        write_reg(REG_ROWS_M,  {12'($urandom), rows});
        write_reg(REG_COLS_N,  {12'($urandom), cols});
        write_reg(REG_DEPTH_K, {12'($urandom), depth});
    endtask

    task automatic write_spare_reg();
        write_reg(REG_BETA_SCALE + CFG_IDX_W'($urandom_range(1, 3)), VAL_W'($urandom));
    endtask

    // fill every store entry the next compute reads that has never been loaded
    task automatic load_missing();
        int m_lim;
        int n_lim;
        int k_lim;
        int r;
        int c;
        m_lim = eff_dim(dim_m);
        n_lim = eff_dim(dim_n);
        k_lim = eff_dim(dim_k);
        for (r = 0; r < m_lim; r++)
            for (c = 0; c < k_lim; c++)
                if (!a_set[r*GRID+c])
                    send_word(OP_LOAD_A, IDX_W'(r), IDX_W'(c), rand_element());
        for (r = 0; r < k_lim; r++)
            for (c = 0; c < n_lim; c++)
                if (!b_set[r*GRID+c])
                    send_word(OP_LOAD_B, IDX_W'(r), IDX_W'(c), rand_element());
        for (r = 0; r < m_lim; r++)
            for (c = 0; c < n_lim; c++)
                if (!c_set[r*GRID+c])
                    send_word(OP_LOAD_C, IDX_W'(r), IDX_W'(c), rand_element());
    endtask

    // one element load inside the live shape of its matrix
    task automatic load_in_shape();
        int m_lim;
        int n_lim;
        int k_lim;
        m_lim = eff_dim(dim_m);
        n_lim = eff_dim(dim_n);
        k_lim = eff_dim(dim_k);
        case ($urandom_range(0, 2))
            0: send_word(OP_LOAD_A, IDX_W'($urandom_range(0, m_lim - 1)),
                         IDX_W'($urandom_range(0, k_lim - 1)), rand_element());
            1: send_word(OP_LOAD_B, IDX_W'($urandom_range(0, k_lim - 1)),
                         IDX_W'($urandom_range(0, n_lim - 1)), rand_element());
            default: send_word(OP_LOAD_C, IDX_W'($urandom_range(0, m_lim - 1)),
                               IDX_W'($urandom_range(0, n_lim - 1)), rand_element());
        endcase
    endtask

    task automatic load_anywhere();
        send_word(op_t'($urandom_range(0, 2)), IDX_W'($urandom), IDX_W'($urandom),
                  rand_element());
    endtask

    // at most one size is large, the rest stay at 0..3
    task automatic pick_random_setup();
        int               big;
        logic [DIM_W-1:0] d [3];
        big = $urandom_range(0, 3);
        for (int i = 0; i < 3; i++)
            d[i] = (i == big)
                 ? (($urandom_range(0, 3) == 0) ? 4'd15 : DIM_W'($urandom_range(4, 8)))
                 : DIM_W'($urandom_range(0, 3));
        set_shape(d[0], d[1], d[2]);
        write_reg(REG_ALPHA_SCALE, rand_scale());
        write_reg(REG_BETA_SCALE, rand_scale());
        if ($urandom_range(0, 4) == 0)
            write_spare_reg();
    endtask

    task automatic run_random_sequence();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 6)
        begin
            // well formed: fresh operands, then compute, sometimes twice
            repeat ($urandom_range(1, 6)) load_in_shape();
            load_missing();
            issue_compute();
            if ($urandom_range(0, 3) == 0)
                issue_compute();
        end
        else if (kind < 8)
        begin
            // stray loads, no compute
            repeat ($urandom_range(1, 4)) load_anywhere();
        end
        else
        begin
            // compute on whatever is stored, loads queued up behind it
            load_missing();
            issue_compute();
            repeat ($urandom_range(1, 3)) load_anywhere();
        end
    endtask

    // saturation both ways, floor rounding, loads outside the shape, beta path
    task automatic test_corner_values();
        set_shape(4'd1, 4'd1, 4'd1);
        write_reg(REG_ALPHA_SCALE, 16'h0100);
        write_reg(REG_BETA_SCALE, 16'h0000);
        send_word(OP_LOAD_A, 3'd0, 3'd0, 16'h7FFF);
        send_word(OP_LOAD_B, 3'd0, 3'd0, 16'h7FFF);
        send_word(OP_LOAD_C, 3'd0, 3'd0, 16'h8000);
        issue_compute();
        send_word(OP_LOAD_A, 3'd0, 3'd0, 16'h8000);
        issue_compute();
        send_word(OP_LOAD_B, 3'd0, 3'd0, 16'h8000);
        issue_compute();
        // tiny negative product must floor to -1, tiny positive to 0
        send_word(OP_LOAD_A, 3'd0, 3'd0, 16'h0001);
        send_word(OP_LOAD_B, 3'd0, 3'd0, 16'hFFFF);
        issue_compute();
        send_word(OP_LOAD_B, 3'd0, 3'd0, 16'h0001);
        issue_compute();
        send_word(OP_LOAD_A, 3'd7, 3'd7, 16'h5A5A);
        send_word(OP_LOAD_B, 3'd7, 3'd7, 16'hA5A5);
        send_word(OP_LOAD_C, 3'd7, 3'd7, 16'hFFFF);
        // beta only, most negative
        wait_idle(CFG_SETTLE);
        write_reg(REG_ALPHA_SCALE, 16'h0000);
        write_reg(REG_BETA_SCALE, 16'h8000);
        send_word(OP_LOAD_C, 3'd0, 3'd0, 16'h7FFF);
        issue_compute();
        wait_idle(CFG_SETTLE);
        write_reg(REG_ALPHA_SCALE, 16'h7FFF);
        write_reg(REG_BETA_SCALE, 16'h7FFF);
        issue_compute();
        // beta of one passes C straight through
        wait_idle(CFG_SETTLE);
        write_reg(REG_ALPHA_SCALE, 16'h0000);
        write_reg(REG_BETA_SCALE, 16'h0100);
        issue_compute();
    endtask

    // sizes of 0 and above 8, each dimension at its top in turn, spare indexes
    task automatic test_size_extremes();
        wait_idle(CFG_SETTLE);
        set_shape(4'd15, 4'd0, 4'd1);
        write_reg(REG_ALPHA_SCALE, rand_scale());
        write_reg(REG_BETA_SCALE, rand_scale());
        load_missing();
        issue_compute();
        wait_idle(CFG_SETTLE);
        set_shape(4'd0, 4'd8, 4'd0);
        load_missing();
        issue_compute();
        wait_idle(CFG_SETTLE);
        set_shape(4'd1, 4'd1, 4'd15);
        for (int i = 1; i <= 3; i++)
            write_reg(REG_BETA_SCALE + CFG_IDX_W'(i), VAL_W'($urandom));
        load_missing();
        issue_compute();
    endtask

    task automatic test_random_sequences();
        while (words_sent < ITEM_TARGET - QUIET_TAIL)
        begin
            gaps_on = ($urandom_range(0, 9) < 7);
            if ($urandom_range(0, 2) == 0)
            begin
                wait_idle(CFG_SETTLE);
                pick_random_setup();
            end
            run_random_sequence();
        end
    endtask

    // closing stretch at full rate, no gaps
    task automatic test_back_to_back();
        gaps_on = 1'b0;
        wait_idle(CFG_SETTLE);
        pick_random_setup();
        while (words_sent < ITEM_TARGET)
            run_random_sequence();
    endtask

    // result checker: every strobed word against the oldest prediction
    always @(posedge clk)
    begin : check_result
        result_word_t want;
        if (rst_n && result_valid)
        begin
            if (pending_elements.size() == 0)
            begin
                $error("unexpected result word: row %0d col %0d value %0d",
                       out_row, out_col, out_value);
                mismatches++;
            end
            else
            begin
                want = pending_elements.pop_front();
                if (out_row !== want.row)
                begin
                    $error("out_row: expected %0d, actual %0d", want.row, out_row);
                    mismatches++;
                end
                if (out_col !== want.col)
                begin
                    $error("out_col: expected %0d, actual %0d", want.col, out_col);
                    mismatches++;
                end
                if (out_value !== want.value)
                begin
                    $error("out_value: expected %0d, actual %0d", $signed(want.value),
                           out_value);
                    mismatches++;
                end
                if (last_result !== want.last)
                begin
                    $error("last_result: expected %0d, actual %0d", want.last, last_result);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with nothing moving
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || cfg_write)
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        operation     = OP_LOAD_A;
        row_index     = '0;
        col_index     = '0;
        element_value = '0;
        cfg_write     = 1'b0;
        cfg_index     = REG_ROWS_M;
        cfg_data      = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_corner_values();
        test_size_extremes();
        test_random_sequences();
        test_back_to_back();

        wait_idle(END_SETTLE);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
hdl/smmsa_pkg.sv
hdl/smmsa_ctrl.sv
hdl/smmsa_datapath.sv
hdl/small_matrix_multiply_scale_add.sv
dv/small_matrix_multiply_scale_add_test.sv
